// ===== hdl/lls_pkg.sv =====
// Shared types and codes for the logical line splitter.
// No dependencies; imported by logical_line_splitter_core.
`default_nettype none

package lls_pkg;

    localparam int CharW  = 8;
    localparam int QDepth = 4;
    localparam int QPtrW  = $clog2(QDepth);
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [CharW-1:0] SepReset  = 8'd59;
    localparam logic [CharW-1:0] ComReset  = 8'd35;
    localparam logic [CharW-1:0] ContReset = 8'd92;

    typedef enum logic [1:0] {
        CMD_CHAR = 2'd0,
        CMD_EOL  = 2'd1,
        CMD_EOI  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_CONT = 2'd1,
        HELD_SEP  = 2'd2
    } held_t;

    typedef enum logic [1:0] {
        REG_SEP  = 2'd0,
        REG_COM  = 2'd1,
        REG_CONT = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic             has_char;
        logic [CharW-1:0] out_char;
        logic             line_end;
        logic             stream_end;
        logic             last;
    } result_t;

    localparam result_t ResultZero = '{
        has_char: 1'b0, out_char: '0, line_end: 1'b0, stream_end: 1'b0, last: 1'b0
    };

endpackage

`default_nettype wire

// ===== hdl/logical_line_splitter_core.sv =====
// Logical line splitter: input handshake, line state, result queue.
// Depends on lls_pkg.
`default_nettype none

// Takes one item (character, end of physical line, end of input) per cycle
// while in_ready is high and produces zero, one or two result items, given
// out one per cycle, while out_ready is high, via a four-entry result queue.
// An item is taken whenever the queue has room for two results, so a stream
// that yields at most one result per item runs at one item per cycle while
// out_ready is high. Results are written into the queue when the item is
// accepted. The user writes separator, comment and continuation codes
// through the cfg port while the block is idle; the block does not enforce it.
module logical_line_splitter_core
    import lls_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CharW-1:0] cfg_data,

    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [1:0]       cmd,
    input  wire logic [CharW-1:0] in_char,

    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  has_char,
    output logic [CharW-1:0]      out_char,
    output logic                  line_end,
    output logic                  stream_end,
    output logic                  last
);

    logic [CharW-1:0] sep_reg, com_reg, cont_reg;

    logic  comment_reg, comment_next;
    held_t held_reg, held_next;
    logic  cont_line_reg, cont_line_next;

    result_t          q_reg [QDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCntW-1:0] count_reg, count_next;

    result_t    res0, res1;
    logic [1:0] n_res;
    logic       accept, pop;
    logic       com_hit;

    assign in_ready  = (count_reg <= QCntW'(QDepth - 2));
    assign accept    = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg  <= SepReset;
            com_reg  <= ComReset;
            cont_reg <= ContReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SEP:  sep_reg  <= cfg_data;
                REG_COM:  com_reg  <= cfg_data;
                REG_CONT: cont_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // Per-item decode: next line state and up to two results.
    always_comb
    begin
        comment_next   = comment_reg;
        held_next      = held_reg;
        cont_line_next = cont_line_reg;
        res0           = ResultZero;
        res1           = ResultZero;
        n_res          = 2'd0;
        com_hit        = comment_reg || (in_char == com_reg);

        unique case (cmd_t'(cmd))
            CMD_CHAR:
            begin
                // a held mark is emitted ahead of the new character
                if (held_reg == HELD_CONT || held_reg == HELD_SEP)
                begin
                    res0.has_char = 1'b1;
                    res0.out_char = (held_reg == HELD_CONT) ? cont_reg : sep_reg;
                    n_res         = 2'd1;
                end
                held_next    = HELD_NONE;
                comment_next = com_hit;

                if (!com_hit && in_char == sep_reg)
                begin
                    res1.line_end  = 1'b1;
                    comment_next   = 1'b0;
                    cont_line_next = 1'b0;
                    n_res          = n_res + 2'd1;
                end
                else if (!com_hit && in_char == cont_reg)
                begin
                    held_next = HELD_CONT;
                end
                else if (com_hit && in_char == sep_reg)
                begin
                    held_next = HELD_SEP;
                end
                else
                begin
                    res1.has_char = 1'b1;
                    res1.out_char = in_char;
                    n_res         = n_res + 2'd1;
                end

                if (n_res == 2'd1 && held_reg == HELD_NONE)
                begin
                    res0 = res1;
                end
            end
            CMD_EOL:
            begin
                if (held_reg == HELD_CONT && !comment_reg)
                begin
                    held_next      = HELD_NONE;
                    comment_next   = 1'b0;
                    cont_line_next = 1'b1;
                end
                else
                begin
                    if (held_reg == HELD_CONT)
                    begin
                        res0.has_char = 1'b1;
                        res0.out_char = cont_reg;
                        res1.line_end = 1'b1;
                        n_res         = 2'd2;
                    end
                    else
                    begin
                        res0.line_end = 1'b1;
                        n_res         = 2'd1;
                    end
                    comment_next   = 1'b0;
                    held_next      = HELD_NONE;
                    cont_line_next = 1'b0;
                end
            end
            CMD_EOI:
            begin
                if (cont_line_reg || held_reg != HELD_NONE || comment_reg)
                begin
                    res0.line_end   = 1'b1;
                    res1.stream_end = 1'b1;
                    n_res           = 2'd2;
                end
                else
                begin
                    res0.stream_end = 1'b1;
                    n_res           = 2'd1;
                end
                comment_next   = 1'b0;
                held_next      = HELD_NONE;
                cont_line_next = 1'b0;
            end
            default: ;
        endcase

        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comment_reg   <= 1'b0;
            held_reg      <= HELD_NONE;
            cont_line_reg <= 1'b0;
        end
        else if (accept)
        begin
            comment_reg   <= comment_next;
            held_reg      <= held_next;
            cont_line_reg <= cont_line_next;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = count_next + QCntW'(n_res);
        end
        if (pop)
        begin
            count_next = count_next - QCntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(n_res);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            end
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept && n_res != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (accept && n_res == 2'd2)
        begin
            q_reg[wr_ptr_reg + QPtrW'(1)] <= res1;
        end
    end

    assign has_char   = q_reg[rd_ptr_reg].has_char;
    assign out_char   = q_reg[rd_ptr_reg].out_char;
    assign line_end   = q_reg[rd_ptr_reg].line_end;
    assign stream_end = q_reg[rd_ptr_reg].stream_end;
    assign last       = q_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire
